/* hw/rtl/iiee_pkg.sv */
// Package for the infix integer expression evaluator: payload structs,
// token and operator codes, sizes and the precedence function. No dependencies.
`default_nettype none
package iiee_pkg;
   localparam int STACK_DEPTH   = 32;
   localparam int NUM_POSITIONS = 16;
   localparam int SP_W  = $clog2(STACK_DEPTH + 1);
   localparam int SA_W  = $clog2(STACK_DEPTH);
   localparam int POS_W = (NUM_POSITIONS > 1) ? $clog2(NUM_POSITIONS) : 1;

   typedef enum logic [2:0] {
      KIND_LIT = 3'd0, KIND_POS = 3'd1, KIND_OPEN = 3'd2, KIND_CLOSE = 3'd3, KIND_OP = 3'd4
   } kind_type;

   localparam logic [3:0] OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3;
   localparam logic [3:0] OP_EQ = 4'd4, OP_NE = 4'd5, OP_LT = 4'd6, OP_LE = 4'd7;
   localparam logic [3:0] OP_GT = 4'd8, OP_GE = 4'd9, OP_AND = 4'd10, OP_OR = 4'd11;
   localparam logic [3:0] OPEN_MARK = 4'd15;

   localparam logic [1:0] ERR_NONE = 2'd0, ERR_DIV0 = 2'd1, ERR_OVF = 2'd2, ERR_FORM = 2'd3;

   typedef struct packed {
      logic        cmd;
      logic [2:0]  token_kind;
      logic [3:0]  op_code;
      logic [3:0]  pos_index;
      logic signed [31:0] operand_value;
      logic        last;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic        result_true;
      logic [1:0]  error_code;
   } rsp_type;

   // Binding level; smaller binds tighter.
   function automatic logic [2:0] level_of(input logic [3:0] op);
      if (op <= 4'd1) return 3'd4;
      if (op <= 4'd3) return 3'd3;
      if (op <= 4'd9) return 3'd5;
      return 3'd6;
   endfunction
endpackage
`default_nettype wire

/* hw/rtl/iiee_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module iiee_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* hw/rtl/iiee_div.sv */
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating.
// Depends on nothing; used by the evaluator top level.
`default_nettype none
module iiee_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [31:0] divisor,
   output logic             done,
   output logic [31:0]      quotient
);
   logic [31:0] rem_ff, rem_in, quo_ff, quo_in, dsr_ff, dsr_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in, busy_ff, busy_in;
   logic [32:0] trial;

   always_comb begin
      rem_in = rem_ff; quo_in = quo_ff; dsr_in = dsr_ff; cnt_in = cnt_ff;
      neg_in = neg_ff; busy_in = busy_ff; done = 1'b0;
      trial = {rem_ff, quo_ff[31]} - {1'b0, dsr_ff};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend[31] ? (32'd0 - dividend) : dividend;
         dsr_in  = divisor[31] ? (32'd0 - divisor) : divisor;
         neg_in  = dividend[31] ^ divisor[31];
         cnt_in  = 6'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff == 6'd32) begin
            busy_in = 1'b0;
            done    = 1'b1;
         end else begin
            cnt_in = cnt_ff + 6'd1;
            if (!trial[32]) begin
               rem_in = trial[31:0];
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = {rem_ff[30:0], quo_ff[31]};
               quo_in = {quo_ff[30:0], 1'b0};
            end
         end
      end
   end
   assign quotient = neg_ff ? (32'd0 - quo_ff) : quo_ff;

   always_ff @(posedge clock) begin
      rem_ff <= rem_in; quo_ff <= quo_in; dsr_ff <= dsr_in; neg_ff <= neg_in;
      if (reset) begin
         busy_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; cnt_ff <= cnt_in;
      end
   end

   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      done |-> busy_ff) else $error("done without busy");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 6'd32) else $error("count overrun");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff) else $error("start did not arm divider");
endmodule
`default_nettype wire

/* hw/rtl/infix_integer_expression_evaluator.sv */
// Top level of the infix integer expression evaluator.
// Depends on iiee_pkg, iiee_ram (operator, value stacks) and iiee_div.
//
// Evaluates pre-tokenized infix expressions with an operator stack and a
// value stack, each held in a 32-entry RAM with registered read; the
// top-of-stack entries are read into registers and written back. One item is
// processed at a time. A literal, reference, open paren or position load goes
// straight to the finish state; a close paren or operator first peeks at the
// operator top and decides. Each operator popped and applied reads two values,
// writes back and reads the next operator, and a division also waits on the
// bit-serial divider. A token marked last starts a flush that walks the
// operator stack, applying each operator still stacked, and then presents one
// result item, held in an output register until taken while the next item is
// accepted behind it; a second result waits until the register frees.
// Errors (divide by zero, stack overflow, malformed) are sticky: the rest of
// the expression is skipped and its result is zero with the first error code.
`default_nettype none
module infix_integer_expression_evaluator (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire iiee_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output iiee_pkg::rsp_type     rsp_data
);
   localparam int SP_W = iiee_pkg::SP_W;
   localparam int SA_W = iiee_pkg::SA_W;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_PEEK  = 9'b000000010, // read operator top
      ST_DEC   = 9'b000000100, // decide pop or finish
      ST_RD_R  = 9'b000001000, // read right value
      ST_RD_L  = 9'b000010000, // read left value
      ST_EXEC  = 9'b000100000, // apply operator
      ST_DIV   = 9'b001000000, // wait for divider
      ST_FIN   = 9'b010000000, // finish token
      ST_OUT   = 9'b100000000  // emit result
   } state_type;

   state_type state_ff, state_in;
   iiee_pkg::req_type tok_ff, tok_in;
   logic [SP_W-1:0] otop_ff, otop_in, vtop_ff, vtop_in;
   logic [1:0]  err_ff, err_in;
   logic        flush_ff, flush_in;
   logic [31:0] pos_ff [iiee_pkg::NUM_POSITIONS];
   logic [3:0]  opc_ff, opc_in;
   logic [31:0] rval_ff, rval_in;
   logic        rsp_valid_ff, rsp_valid_in;
   iiee_pkg::rsp_type rsp_ff, rsp_in;

   // stack RAM ports
   logic            o_we, v_we;
   logic [SA_W-1:0] o_wa, o_ra, v_wa, v_ra;
   logic [3:0]      o_wd, o_rd;
   logic [31:0]     v_wd, v_rd;
   logic            div_start, div_done;
   logic [31:0]     div_q;

   iiee_ram #(.WIDTH(4), .DEPTH(iiee_pkg::STACK_DEPTH)) u_ostack (
      .clock, .wr_en(o_we), .wr_addr(o_wa), .wr_data(o_wd), .rd_addr(o_ra), .rd_data(o_rd));
   iiee_ram #(.WIDTH(32), .DEPTH(iiee_pkg::STACK_DEPTH)) u_vstack (
      .clock, .wr_en(v_we), .wr_addr(v_wa), .wr_data(v_wd), .rd_addr(v_ra), .rd_data(v_rd));
   iiee_div u_div (.clock, .reset, .start(div_start), .dividend(v_rd), .divisor(rval_ff),
      .done(div_done), .quotient(div_q));

   logic [SP_W-1:0] otop_m1, vtop_m1, vtop_m2;
   assign otop_m1 = otop_ff - SP_W'(1);
   assign vtop_m1 = vtop_ff - SP_W'(1);
   assign vtop_m2 = vtop_ff - SP_W'(2);

   // The output register parts the two sides: only a busy sequencer holds the input.
   logic fire_in;
   assign req_ready = (state_ff == ST_IDLE);
   assign fire_in   = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   logic [31:0] pos_rd, alu;
   logic signed [31:0] ls, rs;
   always_comb begin
      pos_rd = '0;
      if (32'(tok_ff.pos_index) < 32'(iiee_pkg::NUM_POSITIONS))
         pos_rd = pos_ff[iiee_pkg::POS_W'(tok_ff.pos_index)];
   end

   always_comb begin
      ls = v_rd; rs = rval_ff;
      unique case (opc_ff)
         iiee_pkg::OP_ADD: alu = v_rd + rval_ff;
         iiee_pkg::OP_SUB: alu = v_rd - rval_ff;
         iiee_pkg::OP_EQ:  alu = {31'd0, ls == rs};
         iiee_pkg::OP_NE:  alu = {31'd0, ls != rs};
         iiee_pkg::OP_LT:  alu = {31'd0, ls < rs};
         iiee_pkg::OP_LE:  alu = {31'd0, ls <= rs};
         iiee_pkg::OP_GT:  alu = {31'd0, ls > rs};
         iiee_pkg::OP_GE:  alu = {31'd0, ls >= rs};
         iiee_pkg::OP_AND: alu = {31'd0, (v_rd != 0) && (rval_ff != 0)};
         iiee_pkg::OP_OR:  alu = {31'd0, (v_rd != 0) || (rval_ff != 0)};
         default:          alu = v_rd * rval_ff;
      endcase
   end

   // Main sequencer.
   always_comb begin
      logic [1:0] e;
      logic pop;
      state_in = state_ff; tok_in = tok_ff; otop_in = otop_ff; vtop_in = vtop_ff;
      err_in = err_ff; flush_in = flush_ff; opc_in = opc_ff; rval_in = rval_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready; rsp_in = rsp_ff;
      o_we = 1'b0; o_wa = otop_ff[SA_W-1:0]; o_wd = tok_ff.op_code;
      o_ra = otop_m1[SA_W-1:0];
      v_we = 1'b0; v_wa = vtop_ff[SA_W-1:0]; v_wd = tok_ff.operand_value;
      v_ra = vtop_m1[SA_W-1:0];
      div_start = 1'b0; e = err_ff; pop = 1'b0;
      unique case (state_ff)
         ST_IDLE: if (fire_in) begin
            tok_in = req_data;
            if (req_data.cmd) begin
               if (err_ff != iiee_pkg::ERR_NONE) state_in = ST_FIN;
               else begin
                  unique case (req_data.token_kind)
                     iiee_pkg::KIND_LIT, iiee_pkg::KIND_POS, iiee_pkg::KIND_OPEN:
                        state_in = ST_FIN;
                     iiee_pkg::KIND_CLOSE: state_in = ST_PEEK;
                     iiee_pkg::KIND_OP: begin
                        if (req_data.op_code > iiee_pkg::OP_OR) begin
                           err_in = iiee_pkg::ERR_FORM; state_in = ST_FIN;
                        end else state_in = ST_PEEK;
                     end
                     default: begin
                        err_in = iiee_pkg::ERR_FORM; state_in = ST_FIN;
                     end
                  endcase
               end
            end else state_in = ST_FIN;
         end
         ST_PEEK: state_in = ST_DEC; // o_ra presents top operator
         ST_DEC: begin
            priority if (err_ff != iiee_pkg::ERR_NONE || otop_ff == '0) begin
               // a close paren with nothing left to match is malformed
               if (!flush_ff && tok_ff.token_kind == iiee_pkg::KIND_CLOSE
                   && err_ff == iiee_pkg::ERR_NONE)
                  err_in = iiee_pkg::ERR_FORM;
               state_in = ST_FIN;
            end else if (flush_ff) begin
               // final flush: an open paren still stacked is unbalanced
               if (o_rd == iiee_pkg::OPEN_MARK) begin
                  err_in = iiee_pkg::ERR_FORM; state_in = ST_FIN;
               end else pop = 1'b1;
            end else if (tok_ff.token_kind == iiee_pkg::KIND_CLOSE) begin
               if (o_rd == iiee_pkg::OPEN_MARK) begin
                  otop_in = otop_m1; state_in = ST_FIN; // drop the matching paren
               end else pop = 1'b1;
            end else begin
               if (o_rd != iiee_pkg::OPEN_MARK &&
                   iiee_pkg::level_of(o_rd) <= iiee_pkg::level_of(tok_ff.op_code))
                  pop = 1'b1;
               else state_in = ST_FIN;
            end
            if (pop) begin
               otop_in = otop_m1; opc_in = o_rd;
               if (vtop_ff < SP_W'(2)) begin
                  err_in = iiee_pkg::ERR_FORM; state_in = ST_FIN;
               end else state_in = ST_RD_R;
            end
         end
         ST_RD_R: begin
            state_in = ST_RD_L; // v_ra = top-1 issued
         end
         ST_RD_L: begin
            rval_in = v_rd; v_ra = vtop_m2[SA_W-1:0]; state_in = ST_EXEC;
         end
         ST_EXEC: begin
            vtop_in = vtop_m1;
            v_wa = vtop_m2[SA_W-1:0];
            if (opc_ff == iiee_pkg::OP_DIV) begin
               if (rval_ff == '0) begin
                  err_in = iiee_pkg::ERR_DIV0; state_in = ST_PEEK;
               end else begin
                  div_start = 1'b1; state_in = ST_DIV;
               end
            end else begin
               v_we = 1'b1; v_wd = alu; state_in = ST_PEEK;
            end
         end
         ST_DIV: begin
            v_wa = vtop_m1[SA_W-1:0]; v_wd = div_q;
            if (div_done) begin
               v_we = 1'b1; state_in = ST_PEEK;
            end
         end
         ST_FIN: begin
            // First entry from IDLE (push work), or after stack walk.
            state_in = ST_IDLE;
            if (tok_ff.cmd && !flush_ff && err_ff == iiee_pkg::ERR_NONE) begin
               unique case (tok_ff.token_kind)
                  iiee_pkg::KIND_LIT, iiee_pkg::KIND_POS: begin
                     if (vtop_ff >= SP_W'(iiee_pkg::STACK_DEPTH)) e = iiee_pkg::ERR_OVF;
                     else begin
                        v_we = 1'b1;
                        v_wd = (tok_ff.token_kind == iiee_pkg::KIND_POS) ? pos_rd
                                                                       : tok_ff.operand_value;
                        vtop_in = vtop_ff + SP_W'(1);
                     end
                  end
                  iiee_pkg::KIND_OPEN, iiee_pkg::KIND_OP: begin
                     if (otop_ff >= SP_W'(iiee_pkg::STACK_DEPTH)) e = iiee_pkg::ERR_OVF;
                     else begin
                        o_we = 1'b1;
                        o_wd = (tok_ff.token_kind == iiee_pkg::KIND_OPEN) ? iiee_pkg::OPEN_MARK
                                                                         : tok_ff.op_code;
                        otop_in = otop_ff + SP_W'(1);
                     end
                  end
                  default: e = err_ff;
               endcase
               err_in = e;
            end
            // After the last token, walk the operator stack once more, then emit.
            if (flush_ff) state_in = ST_OUT;
            else if (tok_ff.cmd && tok_ff.last) begin
               flush_in = 1'b1; state_in = ST_PEEK;
            end
         end
         ST_OUT: begin
            v_ra = '0;
            if (!(rsp_valid_ff && !rsp_ready)) begin
               e = err_ff;
               if (e == iiee_pkg::ERR_NONE && vtop_ff != SP_W'(1)) e = iiee_pkg::ERR_FORM;
               rsp_in.error_code   = e;
               rsp_in.result_value = (e == iiee_pkg::ERR_NONE) ? v_rd : '0;
               rsp_in.result_true  = (e == iiee_pkg::ERR_NONE) && (v_rd != '0);
               rsp_valid_in = 1'b1;
               otop_in = '0; vtop_in = '0; err_in = iiee_pkg::ERR_NONE; flush_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // value stack read address for output: bottom entry
      if (state_in == ST_OUT) v_ra = '0;
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in; opc_ff <= opc_in; rval_ff <= rval_in; rsp_ff <= rsp_in;
      if (reset) begin
         state_ff <= ST_IDLE; otop_ff <= '0; vtop_ff <= '0; err_ff <= '0;
         flush_ff <= 1'b0; rsp_valid_ff <= 1'b0;
         for (int i = 0; i < iiee_pkg::NUM_POSITIONS; i++) pos_ff[i] <= '0;
      end else begin
         state_ff <= state_in; otop_ff <= otop_in; vtop_ff <= vtop_in; err_ff <= err_in;
         flush_ff <= flush_in; rsp_valid_ff <= rsp_valid_in;
         if (fire_in && !req_data.cmd &&
             32'(req_data.pos_index) < 32'(iiee_pkg::NUM_POSITIONS))
            pos_ff[iiee_pkg::POS_W'(req_data.pos_index)] <= req_data.operand_value;
      end
   end

   a_tops: assert property (@(posedge clock) disable iff (reset)
      otop_ff <= SP_W'(iiee_pkg::STACK_DEPTH) && vtop_ff <= SP_W'(iiee_pkg::STACK_DEPTH))
      else $error("stack pointer overrun");
   a_rsp_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && state_in == ST_IDLE) |=> (otop_ff == '0 && vtop_ff == '0))
      else $error("stacks not emptied after result");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.error_code != iiee_pkg::ERR_NONE) |-> rsp_data.result_value == '0)
      else $error("error result not zero");
endmodule
`default_nettype wire
